FILE: src/assert_macros.svh
// Assertion macros for the RTL of the template matcher.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define SSDTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define SSDTM_ASSERT_NEXT(lbl, pre, post, msg) \
  `SSDTM_ASSERT(lbl, (pre) |=> (post), msg)

`endif

FILE: src/ssdtm_pkg.sv
// ----------------------------------------------------------------------------
// ssdtm_pkg
// Shared types and constants of the SSD template matching unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssdtm_pkg;

  localparam int MAX_ROW_LENGTH_DEF = 512;
  localparam int MAX_PATCH_ROWS_DEF = 15;
  localparam int MAX_PATCH_COLS_DEF = 15;

  localparam int PIX_W     = 8;
  localparam int SSD_W     = 24;
  localparam int POS_W     = 9;
  localparam int CFG_W     = 10;
  localparam int PATCH_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_LIMIT = 512;

  localparam logic MODE_TEMPLATE = 1'b0;
  localparam logic MODE_IMAGE    = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH = 2'd0,
    REG_ROW_COUNT  = 2'd1,
    REG_PATCH_ROWS = 2'd2,
    REG_PATCH_COLS = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Window cell control: en moves the cell, shift selects the pixel shift
  // (new column enters at the right edge) instead of the ring rotation.
  typedef struct packed {
    logic en;
    logic shift;
  } win_ctl_t;

  // Line store control: rd reads all rows at one column, wr writes each row the value read from the row above.
  typedef struct packed {
    logic rd;
    logic wr;
  } ls_ctl_t;

endpackage

`default_nettype wire

FILE: src/ssdtm_cell.sv
// ----------------------------------------------------------------------------
// ssdtm_cell
// One window register of the template matcher's cell ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssdtm_cell #(
  parameter bit LAST_COL = 1'b0
) (
  input  wire logic              clk_i,
  input  ssdtm_pkg::win_ctl_t    ctl_i,
  input  ssdtm_pkg::pix_t        next_i,
  input  ssdtm_pkg::pix_t        col_i,
  output ssdtm_pkg::pix_t        pix_o
);
  import ssdtm_pkg::*;

  pix_t pix_q, pix_d;

  // The right neighbor and the ring successor are the same cell, except at
  // the right edge of a row, where a shift takes the new column pixel.
  always_comb begin
    pix_d = pix_q;
    if (ctl_i.en) begin
      if (ctl_i.shift && LAST_COL) begin
        pix_d = col_i;
      end else begin
        pix_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

FILE: src/ssdtm_line_store.sv
// ----------------------------------------------------------------------------
// ssdtm_line_store
// Row buffers that hold the previous image rows, one memory per row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssdtm_line_store #(
  parameter int ROWS  = 14,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  ssdtm_pkg::ls_ctl_t            ctl_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  ssdtm_pkg::pix_t               px_i,
  output ssdtm_pkg::pix_t               rd_o [ROWS]
);
  import ssdtm_pkg::*;

  pix_t rd_q [ROWS];

  // A write follows the read of the same column, so each row takes the
  // value that the row above held there.
  for (genvar k = 0; k < ROWS; k++) begin : g_row
    pix_t mem_q [DEPTH];
    pix_t wr_px;

    if (k == 0) begin : g_first
      assign wr_px = px_i;
    end else begin : g_next
      assign wr_px = rd_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.rd) begin
        rd_q[k] <= mem_q[addr_i];
      end
      if (ctl_i.wr) begin
        mem_q[addr_i] <= wr_px;
      end
    end

    assign rd_o[k] = rd_q[k];
  end

endmodule

`default_nettype wire

FILE: src/ssd_template_match_unit.sv
// ----------------------------------------------------------------------------
// ssd_template_match_unit
// Sum of squared differences between a loaded template and every complete
// window of a raster image stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o | mode_i, pixel_i
//  out     | output    | out_valid_o/out_stall_i | ssd_o, out_row_o, out_col_o,
//          |           |                       | frame_last_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A template item is written to the template memory in IDLE. An image item without a
// result passes through LOAD back to IDLE. An image item with a result goes on
// through SCAN and DONE: the window ring rotates once past a single multiplier.
// Reset needs no clearing pass; line store entries are rewritten before use.
// A stalled result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ssd_template_match_unit #(
  parameter int MAX_ROW_LENGTH = ssdtm_pkg::MAX_ROW_LENGTH_DEF,
  parameter int MAX_PATCH_ROWS = ssdtm_pkg::MAX_PATCH_ROWS_DEF,
  parameter int MAX_PATCH_COLS = ssdtm_pkg::MAX_PATCH_COLS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            mode_i,
  input  wire logic [ssdtm_pkg::PIX_W-1:0]     pixel_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [ssdtm_pkg::SSD_W-1:0]          ssd_o,
  output logic [ssdtm_pkg::POS_W-1:0]          out_row_o,
  output logic [ssdtm_pkg::POS_W-1:0]          out_col_o,
  output logic                                 frame_last_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ssdtm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ssdtm_pkg::CFG_W-1:0]     cfg_data_i
);
  import ssdtm_pkg::*;

  localparam int LS_ROWS = (MAX_PATCH_ROWS > 1) ? MAX_PATCH_ROWS - 1 : 1;
  localparam int N       = MAX_PATCH_ROWS * MAX_PATCH_COLS;
  localparam int TAW     = (N > 1) ? $clog2(N) : 1;
  localparam int PRW     = $clog2(MAX_PATCH_ROWS + 1);
  localparam int PCW     = $clog2(MAX_PATCH_COLS + 1);
  localparam int PW      = PRW + PCW;
  localparam int LAW     = $clog2(MAX_ROW_LENGTH);
  localparam int CW      = $clog2(N + 2);
  localparam int SQ_W    = 2 * PIX_W;
  localparam int RL_HI   = (MAX_ROW_LENGTH < ROW_LIMIT) ? MAX_ROW_LENGTH : ROW_LIMIT;

  state_e state_q, state_d;

  logic [CFG_W-1:0]   row_length_q, row_count_q;
  logic [PATCH_W-1:0] patch_rows_q, patch_cols_q;
  logic [POS_W-1:0]   r_q, c_q;
  logic [TAW-1:0]     tidx_q, taddr_q;
  logic [CW-1:0]      scnt_q;
  logic [PRW-1:0]     sr_q;
  logic [PCW-1:0]     sc_q;
  pix_t               px_q, a_pix_q, t_rd_q;
  logic               a_act_q;
  logic [SQ_W-1:0]    sq_q;
  logic [SSD_W-1:0]   acc_q;
  logic [POS_W-1:0]   res_row_q, res_col_q;
  logic               res_last_q;
  logic               out_valid_q;
  logic [SSD_W-1:0]   ssd_q;
  logic [POS_W-1:0]   out_row_q, out_col_q;
  logic               out_last_q;

  pix_t tpl_mem [N];

  logic [CFG_W-1:0] rl_eff, rc_eff;
  logic [PRW-1:0]   pr_eff, rthr;
  logic [PCW-1:0]   pc_eff, cthr;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    tidx_inc;
  logic             in_acc, cfg_acc, out_acc, out_load;
  logic             produce, col_end, row_end, scan_live, scan_last;
  logic [PIX_W:0]   diff;
  pix_t             absd;
  win_ctl_t         win_ctl;
  ls_ctl_t          ls_ctl;
  pix_t             ls_rd [LS_ROWS];
  pix_t             col_in [MAX_PATCH_ROWS];
  pix_t             cell_pix [N];

  // Effective register values: zero counts as one, large values saturate.
  always_comb begin
    if (row_length_q == '0) begin
      rl_eff = CFG_W'(1);
    end else if (int'(row_length_q) > RL_HI) begin
      rl_eff = CFG_W'(RL_HI);
    end else begin
      rl_eff = row_length_q;
    end
    if (row_count_q == '0) begin
      rc_eff = CFG_W'(1);
    end else if (int'(row_count_q) > ROW_LIMIT) begin
      rc_eff = CFG_W'(ROW_LIMIT);
    end else begin
      rc_eff = row_count_q;
    end
    if (patch_rows_q == '0) begin
      pr_eff = PRW'(1);
    end else if (int'(patch_rows_q) > MAX_PATCH_ROWS) begin
      pr_eff = PRW'(MAX_PATCH_ROWS);
    end else begin
      pr_eff = PRW'(patch_rows_q);
    end
    if (patch_cols_q == '0) begin
      pc_eff = PCW'(1);
    end else if (int'(patch_cols_q) > MAX_PATCH_COLS) begin
      pc_eff = PCW'(MAX_PATCH_COLS);
    end else begin
      pc_eff = PCW'(patch_cols_q);
    end
  end

  assign prod     = PW'(pr_eff) * PW'(pc_eff);
  assign tidx_inc = PW'(tidx_q) + PW'(1);
  assign rthr     = PRW'(MAX_PATCH_ROWS) - pr_eff;
  assign cthr     = PCW'(MAX_PATCH_COLS) - pc_eff;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign col_end   = (CFG_W'(c_q) + CFG_W'(1)) >= rl_eff;
  assign row_end   = (CFG_W'(r_q) + CFG_W'(1)) >= rc_eff;
  assign produce   = ((CFG_W'(r_q) + CFG_W'(1)) >= CFG_W'(pr_eff)) &&
                     ((CFG_W'(c_q) + CFG_W'(1)) >= CFG_W'(pc_eff));
  assign scan_live = scnt_q < CW'(N);
  assign scan_last = scnt_q == CW'(N + 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && mode_i == MODE_IMAGE) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = produce ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o    = 1'b1;
    cfg_ready_o   = 1'b0;
    win_ctl       = '0;
    ls_ctl        = '0;
    unique case (state_q)
      ST_IDLE: begin
        // A pending register write goes first; the item stalls while it is pending.
        in_stall_o  = cfg_valid_i;
        cfg_ready_o = 1'b1;
        ls_ctl.rd   = in_valid_i && mode_i == MODE_IMAGE;
      end
      ST_LOAD: begin
        win_ctl.en    = 1'b1;
        win_ctl.shift = 1'b1;
        ls_ctl.wr     = 1'b1;
      end
      ST_SCAN: begin
        win_ctl.en = scan_live;
      end
      ST_DONE: begin
        win_ctl = '0;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_length_q <= CFG_W'(512);
      row_count_q  <= CFG_W'(512);
      patch_rows_q <= PATCH_W'(15);
      patch_cols_q <= PATCH_W'(15);
      r_q          <= '0;
      c_q          <= '0;
      tidx_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_ROW_LENGTH: row_length_q <= cfg_data_i;
          REG_ROW_COUNT:  row_count_q  <= cfg_data_i;
          REG_PATCH_ROWS: patch_rows_q <= cfg_data_i[PATCH_W-1:0];
          REG_PATCH_COLS: patch_cols_q <= cfg_data_i[PATCH_W-1:0];
          default:        row_length_q <= row_length_q;
        endcase
        r_q    <= '0;
        c_q    <= '0;
        tidx_q <= '0;
      end else if (in_acc && mode_i == MODE_TEMPLATE) begin
        tidx_q <= (tidx_inc >= prod) ? '0 : TAW'(tidx_inc);
      end else if (state_q == ST_LOAD) begin
        if (col_end) begin
          c_q <= '0;
          r_q <= row_end ? '0 : r_q + POS_W'(1);
        end else begin
          c_q <= c_q + POS_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Template memory and the serial squared difference pipeline.
  always_comb begin
    diff = {1'b0, a_pix_q} - {1'b0, t_rd_q};
    absd = diff[PIX_W] ? PIX_W'(~diff + 1'b1) : diff[PIX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && mode_i == MODE_TEMPLATE) begin
      tpl_mem[tidx_q] <= pixel_i;
    end
    if (in_acc) begin
      px_q <= pixel_i;
    end
    if (state_q == ST_LOAD) begin
      acc_q      <= '0;
      scnt_q     <= '0;
      sr_q       <= '0;
      sc_q       <= '0;
      taddr_q    <= '0;
      res_row_q  <= POS_W'(CFG_W'(r_q) + CFG_W'(1) - CFG_W'(pr_eff));
      res_col_q  <= POS_W'(CFG_W'(c_q) + CFG_W'(1) - CFG_W'(pc_eff));
      res_last_q <= row_end && col_end &&
                    (CFG_W'(r_q) + CFG_W'(1) == rc_eff);
    end
    if (state_q == ST_SCAN) begin
      // The ring head is cell 0; after k rotations it holds window entry k.
      a_pix_q <= cell_pix[0];
      a_act_q <= scan_live && (sr_q >= rthr) && (sc_q >= cthr);
      t_rd_q  <= tpl_mem[taddr_q];
      if (scan_live && (sr_q >= rthr) && (sc_q >= cthr)) begin
        taddr_q <= taddr_q + TAW'(1);
      end
      if (scan_live) begin
        if (sc_q == PCW'(MAX_PATCH_COLS - 1)) begin
          sc_q <= '0;
          sr_q <= sr_q + PRW'(1);
        end else begin
          sc_q <= sc_q + PCW'(1);
        end
      end
      sq_q <= a_act_q ? SQ_W'(absd) * SQ_W'(absd) : '0;
      if (scnt_q >= CW'(2)) begin
        acc_q <= acc_q + SSD_W'(sq_q);
      end
      scnt_q <= scnt_q + CW'(1);
    end
    if (out_load) begin
      ssd_q      <= acc_q;
      out_row_q  <= res_row_q;
      out_col_q  <= res_col_q;
      out_last_q <= res_last_q;
    end
  end

  ssdtm_line_store #(
    .ROWS  (LS_ROWS),
    .DEPTH (MAX_ROW_LENGTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .ctl_i  (ls_ctl),
    .addr_i (LAW'(c_q)),
    .px_i   (px_q),
    .rd_o   (ls_rd)
  );

  // New column: the top rows come from the line store, the bottom row is
  // the incoming pixel.
  for (genvar i = 0; i < MAX_PATCH_ROWS; i++) begin : g_col
    if (i == MAX_PATCH_ROWS - 1) begin : g_new
      assign col_in[i] = px_q;
    end else begin : g_old
      assign col_in[i] = ls_rd[MAX_PATCH_ROWS - 2 - i];
    end
  end

  // Window ring in raster order; each cell passes to the one before it.
  for (genvar n = 0; n < N; n++) begin : g_cell
    ssdtm_cell #(
      .LAST_COL ((n % MAX_PATCH_COLS) == MAX_PATCH_COLS - 1)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (win_ctl),
      .next_i (cell_pix[(n + 1) % N]),
      .col_i  (col_in[n / MAX_PATCH_COLS]),
      .pix_o  (cell_pix[n])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign ssd_o        = ssd_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = out_last_q;

  `SSDTM_ASSERT_NEXT(a_done_fills_out, out_load, out_valid_q, "result not registered")
  `SSDTM_ASSERT(a_load_after_image, (state_q == ST_LOAD) |-> $past(in_acc && mode_i == MODE_IMAGE), "load without image item")
  `SSDTM_ASSERT_NEXT(a_scan_tail_idle, (state_q == ST_SCAN) && !scan_live, !a_act_q, "active tap past ring end")
  `SSDTM_ASSERT_NEXT(a_cfg_restart, cfg_acc, (r_q == '0) && (c_q == '0) && (tidx_q == '0), "config did not restart position")

endmodule

`default_nettype wire
